// ===== rtl/core/dskd_pkg.sv =====
// ---------------------------------------------------------------------------
// Key derivation package
// Shared types, SHA-256 constants and round functions for the hash chain.
// ---------------------------------------------------------------------------
`default_nettype none

package dskd_pkg;

   typedef logic [31:0] word_type;
   typedef logic [5:0]  round_type;

   // Working variables of one compression round.
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
      word_type f;
      word_type g;
      word_type h;
   } state_type;

   // Sixteen message schedule words; entry 0 is the word used in this round.
   typedef logic [15:0][31:0] window_type;

   // Control that travels along the chain with each word.
   typedef struct packed {
      logic valid;
      logic ok;
   } tag_type;

   localparam int NumRounds = 64;

   localparam word_type TagHead    = 32'h33535852;
   localparam word_type TagSession = 32'h2D534B33;
   localparam word_type TagPunch   = 32'h2D505433;
   localparam word_type PadWord    = 32'h00008000;
   localparam word_type MsgBits    = 32'd144;

   localparam state_type InitState = '{
      a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
      e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
   };

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_s0(input word_type x);
      big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_s1(input word_type x);
      big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_s0(input word_type x);
      small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_s1(input word_type x);
      small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   // Round constant table.
   function automatic word_type round_k(input round_type idx);
      case (idx)
         6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
         default: round_k = 32'h00000000;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/domain_separated_key_derivation.sv =====
// ---------------------------------------------------------------------------
// Domain separated key derivation
// One-block SHA-256 over a purpose tag, address, port and nonce.
// ---------------------------------------------------------------------------
// A new word is taken in every clock cycle: busy is always low, and the
// chain of 64 round cells plus one output register carries each word's
// result to the ports. The result is shown for one cycle with rsp_valid
// high; the receiver cannot stall it, so it must take every result as it
// comes. An all-zero address gives rsp_ok low and an all-zero digest.
`default_nettype none

module domain_separated_key_derivation
   import dskd_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [31:0] req_address,
   input  wire  [15:0] req_public_port,
   input  wire  [31:0] req_nonce_value,
   input  wire         req_purpose,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [31:0] rsp_digest_w0,
   output logic [31:0] rsp_digest_w1,
   output logic [31:0] rsp_digest_w2,
   output logic [31:0] rsp_digest_w3,
   output logic [31:0] rsp_digest_w4,
   output logic [31:0] rsp_digest_w5,
   output logic [31:0] rsp_digest_w6,
   output logic [31:0] rsp_digest_w7
);

   tag_type    tag_link    [NumRounds + 1];
   state_type  state_link  [NumRounds + 1];
   window_type window_link [NumRounds + 1];

   logic      valid_ff, valid_in;
   logic      ok_ff,    ok_in;
   state_type dig_ff,   dig_in;
   state_type fin;

   assign busy = 1'b0;

   // Build the padded message block at the head of the chain.
   always_comb begin
      tag_link[0].valid = start;
      tag_link[0].ok    = (req_address != 32'd0);
      state_link[0]     = InitState;
      window_link[0]    = '0;
      window_link[0][0] = TagHead;
      window_link[0][1] = req_purpose ? TagPunch : TagSession;
      window_link[0][2] = req_address;
      window_link[0][3] = {req_public_port, req_nonce_value[31:16]};
      window_link[0][4] = {req_nonce_value[15:0], 16'h0000} | PadWord;
      window_link[0][15] = MsgBits;
   end

   // The row of round cells.
   for (genvar r = 0; r < NumRounds; r++) begin : g_round
      dskd_round_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .round_idx(round_type'(r)),
         .tag_i    (tag_link[r]),
         .state_i  (state_link[r]),
         .window_i (window_link[r]),
         .tag_o    (tag_link[r + 1]),
         .state_o  (state_link[r + 1]),
         .window_o (window_link[r + 1])
      );
   end

   // Final feed-forward add, forced to zero for a zero address.
   always_comb begin
      fin = state_link[NumRounds];
      valid_in = tag_link[NumRounds].valid;
      ok_in    = tag_link[NumRounds].ok;
      if (ok_in) begin
         dig_in.a = fin.a + InitState.a;
         dig_in.b = fin.b + InitState.b;
         dig_in.c = fin.c + InitState.c;
         dig_in.d = fin.d + InitState.d;
         dig_in.e = fin.e + InitState.e;
         dig_in.f = fin.f + InitState.f;
         dig_in.g = fin.g + InitState.g;
         dig_in.h = fin.h + InitState.h;
      end else begin
         dig_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff  <= ok_in;
      dig_ff <= dig_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_ok        = ok_ff;
   assign rsp_digest_w0 = dig_ff.a;
   assign rsp_digest_w1 = dig_ff.b;
   assign rsp_digest_w2 = dig_ff.c;
   assign rsp_digest_w3 = dig_ff.d;
   assign rsp_digest_w4 = dig_ff.e;
   assign rsp_digest_w5 = dig_ff.f;
   assign rsp_digest_w6 = dig_ff.g;
   assign rsp_digest_w7 = dig_ff.h;

endmodule

`default_nettype wire

// ===== rtl/core/dskd_round_cell.sv =====
// ---------------------------------------------------------------------------
// Round cell
// One SHA-256 compression round and one message schedule step, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module dskd_round_cell
   import dskd_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  round_type  round_idx,
   input  tag_type    tag_i,
   input  state_type  state_i,
   input  window_type window_i,
   output tag_type    tag_o,
   output state_type  state_o,
   output window_type window_o
);

   tag_type    tag_ff,    tag_in;
   state_type  state_ff,  state_in;
   window_type window_ff, window_in;

   word_type t1;
   word_type t2;
   word_type ch;
   word_type mj;
   word_type w_next;

   // Round update of the working variables.
   always_comb begin
      ch = (state_i.e & state_i.f) ^ (~state_i.e & state_i.g);
      mj = (state_i.a & state_i.b) ^ (state_i.a & state_i.c) ^ (state_i.b & state_i.c);
      t1 = state_i.h + big_s1(state_i.e) + ch + round_k(round_idx) + window_i[0];
      t2 = big_s0(state_i.a) + mj;
      state_in.a = t1 + t2;
      state_in.b = state_i.a;
      state_in.c = state_i.b;
      state_in.d = state_i.c;
      state_in.e = state_i.d + t1;
      state_in.f = state_i.e;
      state_in.g = state_i.f;
      state_in.h = state_i.g;
   end

   // Schedule step: shift the window and append the next expanded word.
   always_comb begin
      w_next = window_i[0] + small_s0(window_i[1]) + window_i[9] + small_s1(window_i[14]);
      for (int j = 0; j < 15; j++) begin
         window_in[j] = window_i[j + 1];
      end
      window_in[15] = w_next;
      tag_in = tag_i;
   end

   // Control is reset; the data words need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff  <= state_in;
      window_ff <= window_in;
   end

   assign tag_o    = tag_ff;
   assign state_o  = state_ff;
   assign window_o = window_ff;

endmodule

`default_nettype wire
